// ===== rtl/c2t_pkg.sv =====
// c2t_pkg: shared types, constants and helper functions for the
// canonical-to-tracking coordinate pipeline. No dependencies.
`timescale 1ns / 1ps

package c2t_pkg;

   localparam int SqrtSteps = 32;       // one result bit per stage
   localparam int QBits     = 61;       // quotient bits kept by the divider
   localparam int Lanes     = 3;        // divider lanes

   localparam int LaneRv = 0;
   localparam int LaneXp = 1;
   localparam int LaneYp = 2;

   localparam logic [1:0] REG_BETA     = 2'd0;
   localparam logic [1:0] REG_MOMENTUM = 2'd1;
   localparam logic [1:0] REG_MASS     = 2'd2;

   localparam logic [31:0] ONE_Q24 = 32'h0100_0000;
   localparam logic [9:0]  SCALE   = 10'd1000;
   localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_NEG = 32'h8000_0000;

   // per-item data that rides along the long pipeline
   typedef struct packed {
      logic [31:0] x_res;
      logic [31:0] y_res;
      logic        pos_sat;
      logic        oneg;
      logic [31:0] omag;
      logic        xp_neg;
      logic        yp_neg;
      logic        l_neg;
      logic [56:0] nx;
      logic [56:0] ny;
      logic [40:0] lmk;
      logic [31:0] dev;
      logic [30:0] p;
      logic        pzero;
   } c2t_side_type;

   // {neg, magnitude} of a two's complement word
   function automatic logic [32:0] split(input logic [31:0] v);
      logic neg;
      neg = v[31];
      return {neg, neg ? 32'd0 - v : v};
   endfunction

   // {clipped, value}: apply sign to a magnitude and clip to 32 bits
   function automatic logic [32:0] sat32(input logic neg, input logic [63:0] mag);
      logic [32:0] r;
      if (!neg) begin
         if (mag > {32'd0, SAT_POS}) r = {1'b1, SAT_POS};
         else r = {1'b0, mag[31:0]};
      end else begin
         if (mag > {32'd0, SAT_NEG}) r = {1'b1, SAT_NEG};
         else r = {1'b0, 32'd0 - mag[31:0]};
      end
      return r;
   endfunction

endpackage

// ===== rtl/c2t_front.sv =====
// c2t_front: sign split, momentum product, position scaling, common
// normalization of P and mass, and P^2 + M^2. Depends on c2t_pkg.
`timescale 1ns / 1ps

module c2t_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [31:0]          pos_x,
   input  logic [31:0]          mom_x,
   input  logic [31:0]          pos_y,
   input  logic [31:0]          mom_y,
   input  logic [31:0]          long_pos,
   input  logic [31:0]          rel_dev,
   input  logic [47:0]          pc0,
   input  logic [47:0]          mass,
   output logic                 out_valid,
   output logic [63:0]          out_sum,
   output c2t_pkg::c2t_side_type out_side
);
   import c2t_pkg::*;

   localparam int IxPx = 0;
   localparam int IxMx = 1;
   localparam int IxPy = 2;
   localparam int IxMy = 3;
   localparam int IxL  = 4;
   localparam int NormStages = 3;

   // stage 1: magnitudes and 1+deltap
   logic              v1_ff;
   logic [31:0]       omag1_ff, omag1_in;
   logic              oneg1_ff, oneg1_in;
   logic [4:0][31:0]  mag1_ff, mag1_in;
   logic [4:0]        neg1_ff, neg1_in;
   logic [31:0]       dev1_ff;
   logic [32:0]       sd;

   always_comb begin
      sd = split(rel_dev);
      {neg1_in[IxPx], mag1_in[IxPx]} = split(pos_x);
      {neg1_in[IxMx], mag1_in[IxMx]} = split(mom_x);
      {neg1_in[IxPy], mag1_in[IxPy]} = split(pos_y);
      {neg1_in[IxMy], mag1_in[IxMy]} = split(mom_y);
      {neg1_in[IxL],  mag1_in[IxL]}  = split(long_pos);
      priority if (!sd[32]) begin
         omag1_in = sd[31:0] + ONE_Q24;
         oneg1_in = 1'b0;
      end else if (sd[31:0] <= ONE_Q24) begin
         omag1_in = ONE_Q24 - sd[31:0];
         oneg1_in = 1'b0;
      end else begin
         omag1_in = sd[31:0] - ONE_Q24;
         oneg1_in = 1'b1;
      end
   end

   // stage 2: products
   logic              v2_ff;
   logic [63:0]       pl2_ff, pl2_in;
   logic [47:0]       ph2_ff, ph2_in;
   logic [4:0][40:0]  k2_ff, k2_in;
   logic [4:0]        neg2_ff;
   logic [31:0]       omag2_ff, dev2_ff;
   logic              oneg2_ff;

   always_comb begin
      pl2_in = omag1_ff * pc0[31:0];
      ph2_in = omag1_ff * pc0[47:32];
      for (int j = 0; j < 5; j++) k2_in[j] = mag1_ff[j] * SCALE;
   end

   // stage 3: full momentum, mass alignment, position results
   logic [79:0]  p3_in;
   logic [32:0]  xr, yr;
   c2t_side_type side3_in;

   always_comb begin
      p3_in = {16'd0, pl2_ff} + {ph2_ff, 32'd0};
      xr = sat32(neg2_ff[IxPx], {31'd0, k2_ff[IxPx][40:8]});
      yr = sat32(neg2_ff[IxPy], {31'd0, k2_ff[IxPy][40:8]});
      side3_in.x_res   = xr[31:0];
      side3_in.y_res   = yr[31:0];
      side3_in.pos_sat = xr[32] | yr[32];
      side3_in.oneg    = oneg2_ff;
      side3_in.omag    = omag2_ff;
      side3_in.xp_neg  = neg2_ff[IxMx];
      side3_in.yp_neg  = neg2_ff[IxMy];
      side3_in.l_neg   = neg2_ff[IxL];
      side3_in.nx      = {k2_ff[IxMx], 16'd0};
      side3_in.ny      = {k2_ff[IxMy], 16'd0};
      side3_in.lmk     = k2_ff[IxL];
      side3_in.dev     = dev2_ff;
      side3_in.p       = '0;
      side3_in.pzero   = 1'b0;
   end

   // stages 3..6: shift P and M right together until both are below 2^31
   logic         vn_ff [0:NormStages];
   logic [79:0]  pn_ff [0:NormStages];
   logic [79:0]  mn_ff [0:NormStages];
   c2t_side_type sn_ff [0:NormStages];
   logic [79:0]  pn_in [1:NormStages];
   logic [79:0]  mn_in [1:NormStages];

   always_comb begin
      logic [79:0] pa, ma;
      int          k;
      for (int j = 0; j < NormStages; j++) begin
         pa = pn_ff[j];
         ma = mn_ff[j];
         for (int h = 0; h < 2; h++) begin
            k = 32 >> (2 * j + h);
            if (((pa | ma) >> (30 + k)) != 80'd0) begin
               pa = pa >> k;
               ma = ma >> k;
            end
         end
         pn_in[j + 1] = pa;
         mn_in[j + 1] = ma;
      end
   end

   // stage 7: squares; stage 8: sum
   logic         v7_ff, v8_ff;
   logic [61:0]  psq7_ff, msq7_ff, psq7_in, msq7_in;
   c2t_side_type s7_ff, s7_in, s8_ff;
   logic [63:0]  sum8_ff;

   always_comb begin
      psq7_in = pn_ff[NormStages][30:0] * pn_ff[NormStages][30:0];
      msq7_in = mn_ff[NormStages][30:0] * mn_ff[NormStages][30:0];
      s7_in = sn_ff[NormStages];
      s7_in.p = pn_ff[NormStages][30:0];
      s7_in.pzero = (pn_ff[NormStages][30:0] == 31'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         for (int j = 0; j <= NormStages; j++) vn_ff[j] <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         vn_ff[0] <= v2_ff;
         for (int j = 1; j <= NormStages; j++) vn_ff[j] <= vn_ff[j - 1];
         v7_ff <= vn_ff[NormStages];
         v8_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      omag1_ff <= omag1_in;
      oneg1_ff <= oneg1_in;
      mag1_ff  <= mag1_in;
      neg1_ff  <= neg1_in;
      dev1_ff  <= rel_dev;
      pl2_ff   <= pl2_in;
      ph2_ff   <= ph2_in;
      k2_ff    <= k2_in;
      neg2_ff  <= neg1_ff;
      omag2_ff <= omag1_ff;
      oneg2_ff <= oneg1_ff;
      dev2_ff  <= dev1_ff;
      pn_ff[0] <= p3_in;
      mn_ff[0] <= {8'd0, mass, 24'd0};
      sn_ff[0] <= side3_in;
      for (int j = 1; j <= NormStages; j++) begin
         pn_ff[j] <= pn_in[j];
         mn_ff[j] <= mn_in[j];
         sn_ff[j] <= sn_ff[j - 1];
      end
      psq7_ff <= psq7_in;
      msq7_ff <= msq7_in;
      s7_ff   <= s7_in;
      sum8_ff <= {2'd0, psq7_ff} + {2'd0, msq7_ff};
      s8_ff   <= s7_ff;
   end

   assign out_valid = v8_ff;
   assign out_sum   = sum8_ff;
   assign out_side  = s8_ff;

endmodule

// ===== rtl/c2t_isqrt.sv =====
// c2t_isqrt: pipelined integer square root, one result bit per stage,
// sideband carried alongside. Depends on c2t_pkg.
`timescale 1ns / 1ps

module c2t_isqrt (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [63:0]          in_radicand,
   input  c2t_pkg::c2t_side_type in_side,
   output logic                 out_valid,
   output logic [31:0]          out_root,
   output c2t_pkg::c2t_side_type out_side
);
   import c2t_pkg::*;

   logic         v_ff    [0:SqrtSteps];
   logic [63:0]  rad_ff  [0:SqrtSteps];
   logic [34:0]  rem_ff  [0:SqrtSteps];
   logic [31:0]  root_ff [0:SqrtSteps];
   c2t_side_type side_ff [0:SqrtSteps];
   logic [63:0]  rad_in  [1:SqrtSteps];
   logic [34:0]  rem_in  [1:SqrtSteps];
   logic [31:0]  root_in [1:SqrtSteps];

   always_comb begin
      logic [34:0] rem2, trial;
      for (int i = 0; i < SqrtSteps; i++) begin
         rem2  = {rem_ff[i][32:0], rad_ff[i][63:62]};
         trial = {1'b0, root_ff[i], 2'b01};
         rad_in[i + 1] = rad_ff[i] << 2;
         if (rem2 >= trial) begin
            rem_in[i + 1]  = rem2 - trial;
            root_in[i + 1] = {root_ff[i][30:0], 1'b1};
         end else begin
            rem_in[i + 1]  = rem2;
            root_in[i + 1] = {root_ff[i][30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= SqrtSteps; i++) v_ff[i] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
         for (int i = 1; i <= SqrtSteps; i++) v_ff[i] <= v_ff[i - 1];
      end
   end

   always_ff @(posedge clock) begin
      rad_ff[0]  <= in_radicand;
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
      side_ff[0] <= in_side;
      for (int i = 1; i <= SqrtSteps; i++) begin
         rad_ff[i]  <= rad_in[i];
         rem_ff[i]  <= rem_in[i];
         root_ff[i] <= root_in[i];
         side_ff[i] <= side_ff[i - 1];
      end
   end

   assign out_valid = v_ff[SqrtSteps];
   assign out_root  = root_ff[SqrtSteps];
   assign out_side  = side_ff[SqrtSteps];

endmodule

// ===== rtl/c2t_div.sv =====
// c2t_div: three-lane pipelined restoring divider, 64-bit dividend by
// 32-bit divisor, quotient clipped to 61 bits. Depends on c2t_pkg.
`timescale 1ns / 1ps

module c2t_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [c2t_pkg::Lanes-1:0][63:0] in_num,
   input  logic [c2t_pkg::Lanes-1:0][31:0] in_den,
   input  c2t_pkg::c2t_side_type          in_side,
   output logic                          out_valid,
   output logic [c2t_pkg::Lanes-1:0][c2t_pkg::QBits-1:0] out_quot,
   output c2t_pkg::c2t_side_type          out_side
);
   import c2t_pkg::*;

   logic                            v_ff    [0:QBits];
   logic [Lanes-1:0][QBits-1:0]     lo_ff   [0:QBits];
   logic [Lanes-1:0][QBits-1:0]     q_ff    [0:QBits];
   logic [Lanes-1:0][31:0]          rem_ff  [0:QBits];
   logic [Lanes-1:0][31:0]          den_ff  [0:QBits];
   logic [Lanes-1:0]                ovf_ff  [0:QBits];
   c2t_side_type                    side_ff [0:QBits];
   logic [Lanes-1:0][QBits-1:0]     lo_in   [1:QBits];
   logic [Lanes-1:0][QBits-1:0]     q_in    [1:QBits];
   logic [Lanes-1:0][31:0]          rem_in  [1:QBits];
   logic [Lanes-1:0]                ovf0_in;

   // quotient overflows 61 bits exactly when num / 2^61 >= den
   always_comb begin
      for (int l = 0; l < Lanes; l++)
         ovf0_in[l] = ({29'd0, in_num[l][63:61]} >= in_den[l]);
   end

   always_comb begin
      logic [32:0] rem2;
      for (int i = 0; i < QBits; i++) begin
         for (int l = 0; l < Lanes; l++) begin
            rem2 = {rem_ff[i][l], lo_ff[i][l][QBits-1]};
            lo_in[i + 1][l] = lo_ff[i][l] << 1;
            if (rem2 >= {1'b0, den_ff[i][l]}) begin
               rem_in[i + 1][l] = 32'(rem2 - {1'b0, den_ff[i][l]});
               q_in[i + 1][l]   = {q_ff[i][l][QBits-2:0], 1'b1};
            end else begin
               rem_in[i + 1][l] = rem2[31:0];
               q_in[i + 1][l]   = {q_ff[i][l][QBits-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= QBits; i++) v_ff[i] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
         for (int i = 1; i <= QBits; i++) v_ff[i] <= v_ff[i - 1];
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < Lanes; l++) begin
         lo_ff[0][l]  <= in_num[l][QBits-1:0];
         rem_ff[0][l] <= {29'd0, in_num[l][63:61]};
      end
      q_ff[0]    <= '0;
      den_ff[0]  <= in_den;
      ovf_ff[0]  <= ovf0_in;
      side_ff[0] <= in_side;
      for (int i = 1; i <= QBits; i++) begin
         lo_ff[i]   <= lo_in[i];
         q_ff[i]    <= q_in[i];
         rem_ff[i]  <= rem_in[i];
         den_ff[i]  <= den_ff[i - 1];
         ovf_ff[i]  <= ovf_ff[i - 1];
         side_ff[i] <= side_ff[i - 1];
      end
   end

   always_comb begin
      for (int l = 0; l < Lanes; l++)
         out_quot[l] = ovf_ff[QBits][l] ? '1 : q_ff[QBits][l];
   end

   assign out_valid = v_ff[QBits];
   assign out_side  = side_ff[QBits];

endmodule

// ===== rtl/c2t_back.sv =====
// c2t_back: transverse angle clipping, longitudinal product
// |long|*1000*rv / 2^39 and output registers. Depends on c2t_pkg.
`timescale 1ns / 1ps

module c2t_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [c2t_pkg::Lanes-1:0][c2t_pkg::QBits-1:0] in_quot,
   input  c2t_pkg::c2t_side_type          in_side,
   output logic                          rsp_valid,
   output logic [31:0]                   rsp_out_x,
   output logic [31:0]                   rsp_out_xp,
   output logic [31:0]                   rsp_out_y,
   output logic [31:0]                   rsp_out_yp,
   output logic [31:0]                   rsp_out_long,
   output logic [31:0]                   rsp_out_dev,
   output logic                          rsp_saturated
);
   import c2t_pkg::*;

   typedef struct packed {
      logic [31:0] x_res;
      logic [31:0] y_res;
      logic [31:0] xp_res;
      logic [31:0] yp_res;
      logic        sat;
      logic        long_neg;
      logic        l_zero;
      logic        pzero;
      logic [31:0] dev;
   } back_side_type;

   function automatic logic [32:0] mom_res(input logic dzero, input logic neg,
                                           input logic oneg, input logic nzero,
                                           input logic [QBits-1:0] q);
      logic [32:0] r;
      if (dzero) begin
         if (nzero) r = {1'b1, 32'd0};
         else r = {1'b1, neg ? SAT_NEG : SAT_POS};
      end else begin
         r = sat32(neg ^ oneg, {{(64 - QBits){1'b0}}, q});
      end
      return r;
   endfunction

   // F1: angles and partial products
   logic          v1_ff, v2_ff, v3_ff;
   back_side_type b1_ff, b1_in, b2_ff, b3_ff;
   logic [63:0]   pp0_ff, pp0_in, pp0b_ff;
   logic [60:0]   pp1_ff, pp1_in;
   logic [40:0]   pp2_ff, pp2_in;
   logic [37:0]   pp3_ff, pp3_in, pp3b_ff;
   logic [61:0]   mid_ff;
   logic [101:0]  tot_ff;
   logic [32:0]   xp, yp;
   logic [QBits-1:0] rv;

   always_comb begin
      xp = mom_res(in_side.omag == 32'd0, in_side.xp_neg, in_side.oneg,
                   in_side.nx == 57'd0, in_quot[LaneXp]);
      yp = mom_res(in_side.omag == 32'd0, in_side.yp_neg, in_side.oneg,
                   in_side.ny == 57'd0, in_quot[LaneYp]);
      rv = in_quot[LaneRv];
      pp0_in = in_side.lmk[31:0] * rv[31:0];
      pp1_in = in_side.lmk[31:0] * rv[60:32];
      pp2_in = in_side.lmk[40:32] * rv[31:0];
      pp3_in = in_side.lmk[40:32] * rv[60:32];
      b1_in.x_res    = in_side.x_res;
      b1_in.y_res    = in_side.y_res;
      b1_in.xp_res   = xp[31:0];
      b1_in.yp_res   = yp[31:0];
      b1_in.sat      = in_side.pos_sat | xp[32] | yp[32];
      b1_in.long_neg = in_side.l_neg ^ in_side.oneg;
      b1_in.l_zero   = (in_side.lmk == 41'd0);
      b1_in.pzero    = in_side.pzero;
      b1_in.dev      = in_side.dev;
   end

   // F4: longitudinal result
   logic [32:0] lr;
   always_comb begin
      if (b3_ff.pzero) begin
         if (b3_ff.l_zero) lr = {1'b1, 32'd0};
         else lr = {1'b1, b3_ff.long_neg ? SAT_NEG : SAT_POS};
      end else begin
         lr = sat32(b3_ff.long_neg, {1'b0, tot_ff[101:39]});
      end
   end

   logic        v4_ff;
   logic [31:0] x4_ff, xp4_ff, y4_ff, yp4_ff, l4_ff, dev4_ff;
   logic        sat4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      b1_ff   <= b1_in;
      pp0_ff  <= pp0_in;
      pp1_ff  <= pp1_in;
      pp2_ff  <= pp2_in;
      pp3_ff  <= pp3_in;
      b2_ff   <= b1_ff;
      mid_ff  <= {1'b0, pp1_ff} + {21'd0, pp2_ff};
      pp0b_ff <= pp0_ff;
      pp3b_ff <= pp3_ff;
      b3_ff   <= b2_ff;
      tot_ff  <= {38'd0, pp0b_ff} + {8'd0, mid_ff, 32'd0} + {pp3b_ff, 64'd0};
      x4_ff   <= b3_ff.x_res;
      y4_ff   <= b3_ff.y_res;
      xp4_ff  <= b3_ff.xp_res;
      yp4_ff  <= b3_ff.yp_res;
      l4_ff   <= lr[31:0];
      dev4_ff <= b3_ff.dev;
      sat4_ff <= b3_ff.sat | lr[32];
   end

   assign rsp_valid     = v4_ff;
   assign rsp_out_x     = x4_ff;
   assign rsp_out_xp    = xp4_ff;
   assign rsp_out_y     = y4_ff;
   assign rsp_out_yp    = yp4_ff;
   assign rsp_out_long  = l4_ff;
   assign rsp_out_dev   = dev4_ff;
   assign rsp_saturated = sat4_ff;

endmodule

// ===== rtl/canonical_to_tracking_coords_core.sv =====
// Canonical-to-tracking coordinate converter, fully pipelined.
// Uses c2t_pkg, c2t_front, c2t_isqrt, c2t_div and c2t_back.
`timescale 1ns / 1ps

// One particle is taken on every cycle that start is high; busy never rises.
// Each result appears on the rsp_ ports for one cycle with rsp_valid, in the
// order of the start beats. Most of the pipeline depth lies in the
// 32-stage square root and the 61-stage divider that forms rv and the angles;
// the receiver must take every beat as it comes. Registers may only be written
// while no particle is in flight.
module canonical_to_tracking_coords_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_mom_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_mom_y,
   input  logic signed [31:0] req_long_pos,
   input  logic signed [31:0] req_rel_dev,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_xp,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_yp,
   output logic signed [31:0] rsp_out_long,
   output logic signed [31:0] rsp_out_dev,
   output logic               rsp_saturated,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [47:0]        csr_data
);
   import c2t_pkg::*;

   logic [31:0] beta_ff;
   logic [47:0] pc0_ff, mass_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff <= 32'h8000_0000;
         pc0_ff  <= 48'd65536;
         mass_ff <= 48'd0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == REG_BETA) beta_ff <= csr_data[31:0];
         if (csr_index == REG_MOMENTUM) pc0_ff <= csr_data;
         if (csr_index == REG_MASS) mass_ff <= csr_data;
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   logic         f_valid;
   logic [63:0]  f_sum;
   c2t_side_type f_side;

   c2t_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start),
      .pos_x    (req_pos_x),
      .mom_x    (req_mom_x),
      .pos_y    (req_pos_y),
      .mom_y    (req_mom_y),
      .long_pos (req_long_pos),
      .rel_dev  (req_rel_dev),
      .pc0      (pc0_ff),
      .mass     (mass_ff),
      .out_valid(f_valid),
      .out_sum  (f_sum),
      .out_side (f_side)
   );

   logic         s_valid;
   logic [31:0]  s_root;
   c2t_side_type s_side;

   c2t_isqrt u_isqrt (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (f_valid),
      .in_radicand(f_sum),
      .in_side    (f_side),
      .out_valid  (s_valid),
      .out_root   (s_root),
      .out_side   (s_side)
   );

   // beta0 * E ahead of the divider
   logic         e_valid_ff;
   logic [63:0]  e_prod_ff, e_prod_in;
   c2t_side_type e_side_ff;

   assign e_prod_in = beta_ff * s_root;

   always_ff @(posedge clock) begin
      if (reset) e_valid_ff <= 1'b0;
      else e_valid_ff <= s_valid;
   end

   always_ff @(posedge clock) begin
      e_prod_ff <= e_prod_in;
      e_side_ff <= s_side;
   end

   logic [Lanes-1:0][63:0] d_num;
   logic [Lanes-1:0][31:0] d_den;

   always_comb begin
      d_num[LaneRv] = e_prod_ff;
      d_den[LaneRv] = {1'b0, e_side_ff.p};
      d_num[LaneXp] = {7'd0, e_side_ff.nx};
      d_den[LaneXp] = e_side_ff.omag;
      d_num[LaneYp] = {7'd0, e_side_ff.ny};
      d_den[LaneYp] = e_side_ff.omag;
   end

   logic                        q_valid;
   logic [Lanes-1:0][QBits-1:0] q_quot;
   c2t_side_type                q_side;

   c2t_div u_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (e_valid_ff),
      .in_num   (d_num),
      .in_den   (d_den),
      .in_side  (e_side_ff),
      .out_valid(q_valid),
      .out_quot (q_quot),
      .out_side (q_side)
   );

   c2t_back u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (q_valid),
      .in_quot      (q_quot),
      .in_side      (q_side),
      .rsp_valid    (rsp_valid),
      .rsp_out_x    (rsp_out_x),
      .rsp_out_xp   (rsp_out_xp),
      .rsp_out_y    (rsp_out_y),
      .rsp_out_yp   (rsp_out_yp),
      .rsp_out_long (rsp_out_long),
      .rsp_out_dev  (rsp_out_dev),
      .rsp_saturated(rsp_saturated)
   );

endmodule

// ===== bench/canonical_to_tracking_coords_core_tb.sv =====
// Testbench for canonical_to_tracking_coords_core: drives particles through the
// pipeline, predicts each result in the bench and compares field by field.
// Depends on c2t_pkg and the RTL of the core.
`timescale 1ns / 1ps

module canonical_to_tracking_coords_core_tb;
   import c2t_pkg::*;

   typedef struct packed {
      logic [31:0] pos_x, mom_x, pos_y, mom_y, long_pos, rel_dev;
   } particle_type;

   typedef struct packed {
      logic [31:0] x, xp, y, yp, lng, dev;
      logic        sat;
   } track_type;

   localparam int DrainCycles = 130;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [31:0] req_pos_x = '0, req_mom_x = '0, req_pos_y = '0;
   logic [31:0] req_mom_y = '0, req_long_pos = '0, req_rel_dev = '0;
   logic rsp_valid, rsp_saturated;
   logic [31:0] rsp_out_x, rsp_out_xp, rsp_out_y, rsp_out_yp, rsp_out_long, rsp_out_dev;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = REG_BETA;
   logic [47:0] csr_data = '0;

   // bench copy of the registers
   logic [31:0] beta_reg = 32'h8000_0000;
   logic [47:0] pc0_reg = 48'd65536;
   logic [47:0] mass_reg = 48'd0;

   track_type pending_tracks[$];
   int mismatches = 0;

   canonical_to_tracking_coords_core i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_pos_x(req_pos_x), .req_mom_x(req_mom_x), .req_pos_y(req_pos_y),
      .req_mom_y(req_mom_y), .req_long_pos(req_long_pos), .req_rel_dev(req_rel_dev),
      .rsp_valid(rsp_valid), .rsp_out_x(rsp_out_x), .rsp_out_xp(rsp_out_xp),
      .rsp_out_y(rsp_out_y), .rsp_out_yp(rsp_out_yp), .rsp_out_long(rsp_out_long),
      .rsp_out_dev(rsp_out_dev), .rsp_saturated(rsp_saturated),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("TEST FAILED");
      $finish;
   end

   // {clipped, word}
   function automatic logic [32:0] clip_word(input logic neg, input logic [63:0] mag);
      if (!neg) begin
         if (mag > 64'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
         return {1'b0, mag[31:0]};
      end
      if (mag > 64'h8000_0000) return {1'b1, 32'h8000_0000};
      return {1'b0, 32'd0 - mag[31:0]};
   endfunction

   function automatic logic [63:0] sqrt_floor(input logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [32:0] angle_of(input logic [31:0] raw, input logic dneg,
                                            input logic [32:0] dmag);
      logic n;
      logic [32:0] m;
      logic [63:0] num;
      n = raw[31];
      m = n ? 33'h1_0000_0000 - {1'b0, raw} : {1'b0, raw};
      if (dmag == 0) begin
         if (m == 0) return {1'b1, 32'd0};
         return {1'b1, n ? 32'h8000_0000 : 32'h7FFF_FFFF};
      end
      num = (64'(m) * 64'd1000) << 16;
      return clip_word(n != dneg, num / 64'(dmag));
   endfunction

   function automatic logic [32:0] position_of(input logic [31:0] raw);
      logic n;
      logic [32:0] m;
      n = raw[31];
      m = n ? 33'h1_0000_0000 - {1'b0, raw} : {1'b0, raw};
      return clip_word(n, (64'(m) * 64'd1000) >> 8);
   endfunction

   function automatic track_type predict_track(input particle_type c);
      track_type t;
      logic dn, ln, oneg, flag, pzero;
      logic [32:0] dm, lm, omag, w;
      logic [127:0] pw, mw, prod;
      logic [63:0] pl, ml, e, rv, lk, mag;
      int len, plen, mlen, s;
      flag = 1'b0;
      dn = c.rel_dev[31];
      dm = dn ? 33'h1_0000_0000 - {1'b0, c.rel_dev} : {1'b0, c.rel_dev};
      if (!dn) begin
         oneg = 1'b0; omag = dm + 33'h100_0000;
      end else if (dm <= 33'h100_0000) begin
         oneg = 1'b0; omag = 33'h100_0000 - dm;
      end else begin
         oneg = 1'b1; omag = dm - 33'h100_0000;
      end
      pw = 128'(pc0_reg) * 128'(omag);
      mw = 128'(mass_reg) << 24;
      plen = 0; mlen = 0;
      for (int i = 0; i < 128; i++) begin
         if (pw[i]) plen = i + 1;
         if (mw[i]) mlen = i + 1;
      end
      len = (mlen > plen) ? mlen : plen;
      s = (len > 31) ? len - 31 : 0;
      pl = 64'(pw >> s);
      ml = 64'(mw >> s);
      pzero = (pl == 0);
      rv = 0;
      if (!pzero) begin
         e = sqrt_floor(pl * pl + ml * ml);
         rv = (64'(beta_reg) * e) / pl;
      end
      w = position_of(c.pos_x); t.x = w[31:0]; flag |= w[32];
      w = angle_of(c.mom_x, oneg, omag); t.xp = w[31:0]; flag |= w[32];
      w = position_of(c.pos_y); t.y = w[31:0]; flag |= w[32];
      w = angle_of(c.mom_y, oneg, omag); t.yp = w[31:0]; flag |= w[32];
      ln = c.long_pos[31];
      lm = ln ? 33'h1_0000_0000 - {1'b0, c.long_pos} : {1'b0, c.long_pos};
      if (pzero) begin
         flag = 1'b1;
         t.lng = (lm == 0) ? 32'd0 : ((ln != oneg) ? 32'h8000_0000 : 32'h7FFF_FFFF);
      end else begin
         lk = 64'(lm) * 64'd1000;
         prod = 128'(lk) * 128'(rv);
         mag = (prod[127:103] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : prod[102:39];
         w = clip_word(ln != oneg, mag); t.lng = w[31:0]; flag |= w[32];
      end
      t.dev = c.rel_dev;
      t.sat = flag;
      return t;
   endfunction

   // a particle is taken at each edge with start high and busy low
   always @(posedge clock) begin
      if (!reset && start && !busy)
         pending_tracks.push_back(predict_track({req_pos_x, req_mom_x, req_pos_y,
                                                 req_mom_y, req_long_pos, req_rel_dev}));
   end

   always @(posedge clock) begin
      track_type got, want;
      if (!reset && rsp_valid) begin
         got = {rsp_out_x, rsp_out_xp, rsp_out_y, rsp_out_yp, rsp_out_long,
                rsp_out_dev, rsp_saturated};
         if (pending_tracks.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", got);
         end else begin
            want = pending_tracks.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: x %h/%h xp %h/%h y %h/%h yp %h/%h",
                            " long %h/%h dev %h/%h sat %b/%b (exp/got)"},
                     want.x, got.x, want.xp, got.xp, want.y, got.y, want.yp, got.yp,
                     want.lng, got.lng, want.dev, got.dev, want.sat, got.sat);
            end
         end
      end
   end

   task automatic send_particle(input particle_type c);
      req_pos_x <= c.pos_x; req_mom_x <= c.mom_x; req_pos_y <= c.pos_y;
      req_mom_y <= c.mom_y; req_long_pos <= c.long_pos; req_rel_dev <= c.rel_dev;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic random_gap();
      int n;
      n = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 150);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_tracks.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [47:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         REG_BETA: beta_reg = value[31:0];
         REG_MOMENTUM: pc0_reg = value;
         REG_MASS: mass_reg = value;
         default: ;
      endcase
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'd0;
         3: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1;
         4: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
         default: return $urandom;
      endcase
   endfunction

   function automatic particle_type random_particle();
      particle_type c;
      c = {pick_word(), pick_word(), pick_word(), pick_word(), pick_word(), pick_word()};
      case ($urandom_range(0, 7))
         0: c.rel_dev = 32'hFF00_0000;                      // 1+deltap is zero
         1: c.rel_dev = 32'hFF00_0000 - $urandom_range(0, 32'h0400_0000);
         2: c.rel_dev = 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
         default: ;
      endcase
      return c;
   endfunction

   task automatic test_directed();
      particle_type c;
      send_particle('0);
      send_particle({6{32'h7FFF_FFFF}});
      send_particle({6{32'h8000_0000}});
      send_particle({6{32'hFFFF_FFFF}});
      send_particle({32'h0100_0000, 32'h0010_0000, 32'hFF00_0000, 32'hFFF0_0000,
                     32'h0200_0000, 32'h0000_0000});
      // one plus deltap zero, with and without momentum
      send_particle({32'd5, 32'd0, 32'd5, 32'd0, 32'd0, 32'hFF00_0000});
      send_particle({32'd5, 32'd7, 32'd5, 32'hFFFF_FFF9, 32'd3, 32'hFF00_0000});
      // negative one plus deltap
      send_particle({32'd1, 32'h0100_0000, 32'd1, 32'hFF00_0000, 32'h0100_0000,
                     32'hFE00_0000});
      send_particle({32'h0080_0000, 32'h1234_5678, 32'hF080_0000, 32'h0000_0001,
                     32'hFF00_0000, 32'h0080_0000});
      for (int i = 0; i < 8; i++) begin
         c = random_particle();
         send_particle(c);
         random_gap();
      end
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) begin
         send_particle(random_particle());
         random_gap();
      end
   endtask

   task automatic test_settings();
      // zero momentum: P vanishes
      write_reg(REG_MOMENTUM, 48'd0);
      test_random(40);
      write_reg(REG_MOMENTUM, 48'hFFFF_FFFF_FFFF);
      write_reg(REG_MASS, 48'hFFFF_FFFF_FFFF);
      write_reg(REG_BETA, 48'hFFFF_FFFF_FFFF);   // upper bits dropped
      test_random(60);
      write_reg(REG_BETA, 48'd0);
      write_reg(REG_MASS, 48'd0);
      test_random(40);
      write_reg(REG_BETA, 48'h8000_0000);
      write_reg(REG_MOMENTUM, 48'd1);
      write_reg(REG_MASS, 48'hFFFF_FFFF_FFFF);  // mass dominates
      test_random(40);
      // random beta, momentum and mass settings
      for (int k = 0; k < 6; k++) begin
         write_reg(REG_BETA, 48'($urandom_range(0, 32'h8000_0000)));
         write_reg(REG_MOMENTUM, {16'($urandom_range(0, 3)), $urandom} >> $urandom_range(0, 20));
         write_reg(REG_MASS, {16'($urandom), $urandom} >> $urandom_range(4, 40));
         test_random(70);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(90);
      test_settings();
      drain();
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
